[rtl/ttrt_pkg.sv]
// ----------------------------------------------------------------------------
// ttrt_pkg
// Shared types and constants of the tagged text record tokenizer: character
// codes, event kinds, sequencer states and the result structs.
// ----------------------------------------------------------------------------
package ttrt_pkg;

	// default depth of the trailing blank fifo
	localparam int BLANK_FIFO_DEPTH_DEF = 16;

	// character codes
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// event kind codes on the result channel
	typedef enum logic [1:0] {
		EV_PARAM_BYTE = 2'd0,
		EV_PARAM_END  = 2'd1,
		EV_VALUE_START = 2'd2
	} event_kind_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHAR,
		ST_FL_RD,
		ST_FL_DATA,
		ST_OV_RD,
		ST_OV_DATA,
		ST_BYTE,
		ST_END,
		ST_START,
		ST_DISPATCH,
		ST_FIN
	} ttrt_state_t;

	// one result without the run marker
	typedef struct packed {
		event_kind_t event_kind;
		logic [7:0]  param_byte;
		logic        trim_overflow;
	} rslt_t;

	// requests from the sequencer to the output stage
	typedef struct packed {
		logic  push;
		logic  finish;
		rslt_t rslt;
	} out_req_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	endfunction

	function automatic logic is_eol(input logic [7:0] b);
		return (b == CH_CR) || (b == CH_LF);
	endfunction

endpackage

[rtl/ttrt_if.sv]
// ----------------------------------------------------------------------------
// ttrt_if
// Valid/ready channels of the tokenizer: text bytes in, events out.
// ----------------------------------------------------------------------------
interface ttrt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface ttrt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [7:0] param_byte;
	logic       trim_overflow;
	logic       last_of_run;

	modport source (output valid, output event_kind, output param_byte,
		output trim_overflow, output last_of_run, input ready);
	modport sink (input valid, input event_kind, input param_byte,
		input trim_overflow, input last_of_run, output ready);
endinterface

[rtl/ttrt_blank_ram.sv]
// ----------------------------------------------------------------------------
// ttrt_blank_ram
// Holding memory for trailing blanks: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ttrt_blank_ram import ttrt_pkg::*; #(
	parameter int DEPTH = BLANK_FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [7:0]           wr_data,
	input  logic                 rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [7:0]           rd_data
);

	logic [7:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/ttrt_out.sv]
// ----------------------------------------------------------------------------
// ttrt_out
// Result output stage: a hold register keeps the newest result back until it
// is known whether it ends the run of its input byte, then moves it to the
// output register.
// ----------------------------------------------------------------------------
module ttrt_out import ttrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  out_req_t req,
	output logic     can_take,
	ttrt_out_if.source out_ch
);

	rslt_t hold_q;
	logic  hold_v_q;
	rslt_t out_q;
	logic  out_last_q;
	logic  out_v_q;

	logic slot_free;
	logic load_out;
	logic load_last;

	// output slot frees when empty or transferred
	assign slot_free = !out_v_q || out_ch.ready;
	assign can_take  = !hold_v_q || slot_free;

	// move held result on a new push (not last) or on finish (last)
	always_comb begin
		load_out  = can_take && hold_v_q && (req.push || req.finish);
		load_last = req.finish;
	end

	// control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (slot_free) begin
				out_v_q <= 1'b0;
			end
			if (can_take && req.push) begin
				hold_v_q <= 1'b1;
			end else if (can_take && req.finish) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q      <= hold_q;
			out_last_q <= load_last;
		end
		if (can_take && req.push) begin
			hold_q <= req.rslt;
		end
	end

	// channel drive
	assign out_ch.valid         = out_v_q;
	assign out_ch.event_kind    = out_q.event_kind;
	assign out_ch.param_byte    = out_q.param_byte;
	assign out_ch.trim_overflow = out_q.trim_overflow;
	assign out_ch.last_of_run   = out_last_q;

endmodule

[rtl/ttrt_ctrl.sv]
// ----------------------------------------------------------------------------
// ttrt_ctrl
// Parse sequencer: decodes each accepted byte, keeps the parse flags and the
// blank fifo pointers, reads and writes the blank memory and issues events.
// ----------------------------------------------------------------------------
module ttrt_ctrl import ttrt_pkg::*; #(
	parameter int DEPTH = BLANK_FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	ttrt_in_if.sink    in_ch,
	output out_req_t   req,
	input  logic       can_take,
	output logic       rd_en,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	input  logic [7:0] rd_data,
	output logic       wr_en,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	output logic [7:0] wr_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = $clog2(2 * DEPTH);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LIT,
		ACT_DROP,
		ACT_COLON,
		ACT_SEMI,
		ACT_ESC,
		ACT_OPEN
	} act_t;

	ttrt_state_t state_q, state_d;

	// parse flags and config
	logic unesc_q;
	logic in_record_q;
	logic in_comment_q;
	logic slash_q;
	logic esc_q;
	logic line_blank_q;

	// per item context
	logic [7:0] byte_q;
	logic [7:0] cur_q;
	logic       lit_q;
	logic       more_q;
	logic       eot_q;
	logic       clr_q;
	logic       start_q;
	logic       after_byte_q;

	// fifo pointers
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	logic             acc;
	logic             a_has, a_lit, a_more, a_esc, a_com, a_sl;
	logic [7:0]       a_char;
	act_t             act;
	logic             c_blank, c_full, c_empty, cnt_one;
	logic [SUM_W-1:0] sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] head_inc;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign acc         = in_ch.valid && in_ch.ready;

	// fifo arithmetic
	assign c_blank  = is_blank(cur_q);
	assign c_full   = (count_q == CNT_W'(DEPTH));
	assign c_empty  = (count_q == '0);
	assign cnt_one  = (count_q == CNT_W'(1));
	assign sum      = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail     = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	// decode of an accepted byte against escape, comment and held slash
	always_comb begin
		a_has  = 1'b0;
		a_lit  = 1'b0;
		a_more = 1'b0;
		a_char = in_ch.data_byte;
		a_esc  = esc_q;
		a_com  = in_comment_q;
		a_sl   = slash_q;
		priority if (esc_q) begin
			a_esc = 1'b0;
			a_has = in_record_q;
			a_lit = 1'b1;
		end else if (in_comment_q) begin
			if (in_ch.data_byte == CH_LF) begin
				a_com = 1'b0;
				a_has = 1'b1;
			end
		end else if (slash_q) begin
			a_sl = 1'b0;
			if (in_ch.data_byte == CH_SLASH) begin
				a_com = 1'b1;
			end else begin
				a_has  = 1'b1;
				a_char = CH_SLASH;
				a_more = 1'b1;
			end
		end else if (in_ch.data_byte == CH_SLASH && !in_ch.end_of_text) begin
			a_sl = 1'b1;
		end else begin
			a_has = 1'b1;
		end
	end

	// action for the current character
	always_comb begin
		act = ACT_NONE;
		priority if (lit_q) begin
			act = ACT_LIT;
		end else if (in_record_q) begin
			priority if (cur_q == CH_HASH) begin
				act = line_blank_q ? ACT_DROP : ACT_LIT;
			end else if (cur_q == CH_COLON) begin
				act = ACT_COLON;
			end else if (cur_q == CH_SEMI) begin
				act = ACT_SEMI;
			end else if (cur_q == CH_BSL && unesc_q) begin
				act = ACT_ESC;
			end else begin
				act = ACT_LIT;
			end
		end else begin
			priority if (cur_q == CH_HASH) begin
				act = ACT_OPEN;
			end else if (cur_q == CH_BSL && unesc_q) begin
				act = ACT_ESC;
			end else begin
				act = ACT_NONE;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = a_has ? ST_CHAR : ST_DISPATCH;
				end
			end
			ST_CHAR: begin
				unique case (act)
					ACT_LIT: begin
						if (c_blank) begin
							state_d = c_full ? ST_OV_RD : ST_DISPATCH;
						end else begin
							state_d = c_empty ? ST_BYTE : ST_FL_RD;
						end
					end
					ACT_DROP:             state_d = ST_END;
					ACT_COLON, ACT_SEMI:  state_d = c_empty ? ST_END : ST_FL_RD;
					ACT_OPEN:             state_d = ST_START;
					default:              state_d = ST_DISPATCH;
				endcase
			end
			ST_FL_RD:   state_d = ST_FL_DATA;
			ST_FL_DATA: begin
				if (can_take) begin
					if (cnt_one) begin
						state_d = after_byte_q ? ST_BYTE : ST_END;
					end else begin
						state_d = ST_FL_RD;
					end
				end
			end
			ST_OV_RD:   state_d = ST_OV_DATA;
			ST_OV_DATA: if (can_take) state_d = ST_DISPATCH;
			ST_BYTE:    if (can_take) state_d = ST_DISPATCH;
			ST_END:     if (can_take) state_d = start_q ? ST_START : ST_DISPATCH;
			ST_START:   if (can_take) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				priority if (more_q) begin
					state_d = ST_CHAR;
				end else if (eot_q && in_record_q) begin
					state_d = c_empty ? ST_END : ST_FL_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:     if (can_take) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs to the memory and the output stage
	always_comb begin
		req             = '0;
		req.rslt.event_kind = EV_PARAM_BYTE;
		rd_en           = (state_q == ST_FL_RD) || (state_q == ST_OV_RD);
		wr_en           = 1'b0;
		unique case (state_q)
			ST_CHAR: begin
				wr_en = (act == ACT_LIT) && c_blank && !c_full;
			end
			ST_FL_DATA: begin
				req.push            = 1'b1;
				req.rslt.param_byte = rd_data;
			end
			ST_OV_DATA: begin
				req.push               = 1'b1;
				req.rslt.param_byte    = rd_data;
				req.rslt.trim_overflow = 1'b1;
				wr_en                  = can_take;
			end
			ST_BYTE: begin
				req.push            = 1'b1;
				req.rslt.param_byte = cur_q;
			end
			ST_END: begin
				req.push            = 1'b1;
				req.rslt.event_kind = EV_PARAM_END;
			end
			ST_START: begin
				req.push            = 1'b1;
				req.rslt.event_kind = EV_VALUE_START;
			end
			ST_FIN: begin
				req.finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = head_q;
	assign wr_addr = tail;
	assign wr_data = cur_q;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			unesc_q      <= 1'b1;
			in_record_q  <= 1'b0;
			in_comment_q <= 1'b0;
			slash_q      <= 1'b0;
			esc_q        <= 1'b0;
			line_blank_q <= 1'b1;
			lit_q        <= 1'b0;
			more_q       <= 1'b0;
			eot_q        <= 1'b0;
			clr_q        <= 1'b0;
			start_q      <= 1'b0;
			after_byte_q <= 1'b0;
			head_q       <= '0;
			count_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				unesc_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						lit_q        <= a_lit;
						more_q       <= a_more;
						eot_q        <= in_ch.end_of_text;
						clr_q        <= in_ch.end_of_text;
						start_q      <= 1'b0;
						esc_q        <= a_esc;
						in_comment_q <= a_com;
						slash_q      <= a_sl;
					end
				end
				ST_CHAR: begin
					unique case (act)
						ACT_LIT: begin
							if (c_blank) begin
								if (!c_full) begin
									count_q <= count_q + 1'b1;
									if (is_eol(cur_q)) begin
										line_blank_q <= 1'b1;
									end
								end
							end else begin
								line_blank_q <= 1'b0;
								after_byte_q <= 1'b1;
							end
						end
						ACT_DROP: begin
							count_q <= '0;
							start_q <= 1'b1;
						end
						ACT_COLON: begin
							line_blank_q <= 1'b1;
							after_byte_q <= 1'b0;
							start_q      <= 1'b0;
						end
						ACT_SEMI: begin
							in_record_q  <= 1'b0;
							after_byte_q <= 1'b0;
							start_q      <= 1'b0;
						end
						ACT_ESC: begin
							esc_q <= 1'b1;
						end
						ACT_OPEN: begin
							in_record_q  <= 1'b1;
							line_blank_q <= 1'b1;
							count_q      <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_FL_DATA: begin
					if (can_take) begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end
				end
				ST_OV_DATA: begin
					if (can_take) begin
						head_q <= head_inc;
						if (is_eol(cur_q)) begin
							line_blank_q <= 1'b1;
						end
					end
				end
				ST_DISPATCH: begin
					priority if (more_q) begin
						lit_q  <= 1'b0;
						more_q <= 1'b0;
					end else if (eot_q) begin
						eot_q        <= 1'b0;
						after_byte_q <= 1'b0;
						start_q      <= 1'b0;
					end else begin
					end
				end
				ST_FIN: begin
					if (can_take && clr_q) begin
						clr_q        <= 1'b0;
						in_record_q  <= 1'b0;
						in_comment_q <= 1'b0;
						slash_q      <= 1'b0;
						esc_q        <= 1'b0;
						line_blank_q <= 1'b1;
						count_q      <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// byte payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			byte_q <= in_ch.data_byte;
			cur_q  <= a_char;
		end else if (state_q == ST_DISPATCH && more_q) begin
			cur_q <= byte_q;
		end
	end

endmodule

[rtl/tagged_text_record_tokenizer.sv]
// ----------------------------------------------------------------------------
// tagged_text_record_tokenizer
// Splits '#A:B:C;' text into value start, parameter byte and parameter end
// events, with comments, escapes and trailing blank trimming.
// ----------------------------------------------------------------------------
// The first event of a byte enters the hold register and is moved on to the output register
// when the next event or the end mark of that byte follows.
// A new byte is taken only in the idle state, once every event of the last byte is issued;
// held blanks are read back or pushed out one at a time, and output stalls hold the sequencer.
// Reset: parse flags cleared, blank fifo emptied, unescape_enable 1, memory not cleared.
module tagged_text_record_tokenizer import ttrt_pkg::*; #(
	parameter int BLANK_FIFO_DEPTH = BLANK_FIFO_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	ttrt_in_if.sink    in_ch,
	ttrt_out_if.source out_ch
);

	localparam int PTR_W = (BLANK_FIFO_DEPTH > 1) ? $clog2(BLANK_FIFO_DEPTH) : 1;

	out_req_t         req;
	logic             can_take;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic [7:0]       wr_data;

	// parse sequencer
	ttrt_ctrl #(
		.DEPTH(BLANK_FIFO_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.req        (req),
		.can_take   (can_take),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// trailing blank memory
	ttrt_blank_ram #(
		.DEPTH(BLANK_FIFO_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// result output stage
	ttrt_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.can_take(can_take),
		.out_ch  (out_ch)
	);

endmodule

[bench/tagged_text_record_tokenizer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tagged_text_record_tokenizer_tb
// Self-checking bench for the record tokenizer. Text bytes go in over a
// valid/ready channel with random gaps. Events come out under random
// backpressure, and each event is compared with a built-in tokenizer model.
// The unescape register is switched between phases while the block is idle.
// ----------------------------------------------------------------------------
module tagged_text_record_tokenizer_tb;
	import ttrt_pkg::*;

	localparam int BLANK_DEPTH  = BLANK_FIFO_DEPTH_DEF;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_WAIT  = 20;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_REPORTS  = 10;

	// one expected or observed event
	typedef struct {
		event_kind_t kind;
		logic [7:0]  pbyte;
		logic        ovf;
		logic        last;
	} event_rec_t;

	// tokenizer model and store of expected events
	class event_scoreboard;
		bit          unescape;
		bit          in_rec;
		bit          in_cmt;
		bit          slash_hold;
		bit          esc_hold;
		bit          line_blank;
		logic [7:0]  blanks[BLANK_DEPTH];
		int unsigned n_blanks;
		event_rec_t  step_q[$];
		event_rec_t  expected_q[$];
		int          errors;

		function new();
			unescape = 1'b1;
			errors = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			in_rec = 1'b0;
			in_cmt = 1'b0;
			slash_hold = 1'b0;
			esc_hold = 1'b0;
			line_blank = 1'b1;
			n_blanks = 0;
		endfunction

		function void emit(event_kind_t k, logic [7:0] b, logic ovf);
			event_rec_t r;
			r.kind = k;
			r.pbyte = (k == EV_PARAM_BYTE) ? b : 8'h00;
			r.ovf = ovf;
			r.last = 1'b0;
			step_q.insert(step_q.size(), r);
		endfunction

		function void flush_blanks();
			for (int k = 0; k < n_blanks; k++)
				emit(EV_PARAM_BYTE, blanks[k], 1'b0);
			n_blanks = 0;
		endfunction

		// ordinary byte inside a parameter, blanks held back
		function void take_literal(logic [7:0] b);
			if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
				if (n_blanks >= BLANK_DEPTH) begin
					emit(EV_PARAM_BYTE, blanks[0], 1'b1);
					for (int k = 0; k < BLANK_DEPTH - 1; k++)
						blanks[k] = blanks[k + 1];
					n_blanks = BLANK_DEPTH - 1;
				end
				blanks[n_blanks] = b;
				n_blanks++;
				if (b == CH_CR || b == CH_LF)
					line_blank = 1'b1;
			end else begin
				flush_blanks();
				emit(EV_PARAM_BYTE, b, 1'b0);
				line_blank = 1'b0;
			end
		endfunction

		function void handle(logic [7:0] b);
			if (in_rec) begin
				if (b == CH_HASH) begin
					if (line_blank) begin
						// hash at line start closes the record, trailing blanks dropped
						n_blanks = 0;
						emit(EV_PARAM_END, 8'h00, 1'b0);
						emit(EV_VALUE_START, 8'h00, 1'b0);
						line_blank = 1'b1;
					end else begin
						take_literal(b);
					end
				end else if (b == CH_COLON) begin
					flush_blanks();
					emit(EV_PARAM_END, 8'h00, 1'b0);
					line_blank = 1'b1;
				end else if (b == CH_SEMI) begin
					flush_blanks();
					emit(EV_PARAM_END, 8'h00, 1'b0);
					in_rec = 1'b0;
				end else if (b == CH_BSL && unescape) begin
					esc_hold = 1'b1;
				end else begin
					take_literal(b);
				end
			end else begin
				if (b == CH_HASH) begin
					emit(EV_VALUE_START, 8'h00, 1'b0);
					in_rec = 1'b1;
					line_blank = 1'b1;
					n_blanks = 0;
				end else if (b == CH_BSL && unescape) begin
					esc_hold = 1'b1;
				end
			end
		endfunction

		// predict the events of one accepted text byte
		function void note_input(logic [7:0] b, logic eot);
			step_q.delete();
			if (esc_hold) begin
				esc_hold = 1'b0;
				if (in_rec)
					take_literal(b);
			end else if (in_cmt) begin
				if (b == CH_LF) begin
					in_cmt = 1'b0;
					handle(b);
				end
			end else if (slash_hold) begin
				slash_hold = 1'b0;
				if (b == CH_SLASH) begin
					in_cmt = 1'b1;
				end else begin
					handle(CH_SLASH);
					handle(b);
				end
			end else if (b == CH_SLASH && !eot) begin
				slash_hold = 1'b1;
			end else begin
				handle(b);
			end
			// end of text closes an open parameter untrimmed
			if (eot) begin
				if (in_rec) begin
					flush_blanks();
					emit(EV_PARAM_END, 8'h00, 1'b0);
				end
				clear_parse();
			end
			if (step_q.size() > 0)
				step_q[step_q.size() - 1].last = 1'b1;
			foreach (step_q[k])
				expected_q.insert(expected_q.size(), step_q[k]);
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] pbyte, logic ovf,
			logic last);
			event_rec_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected event: kind %0d byte %02h ovf %0b last %0b",
						kind, pbyte, ovf, last);
				return;
			end
			e = expected_q.pop_front();
			if (kind !== e.kind || pbyte !== e.pbyte || ovf !== e.ovf || last !== e.last)
			begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("event mismatch: expected kind %0d byte %02h ovf %0b last %0b,",
						e.kind, e.pbyte, e.ovf, e.last,
						" got kind %0d byte %02h ovf %0b last %0b",
						kind, pbyte, ovf, last);
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	ttrt_in_if  text_ch();
	ttrt_out_if event_ch();

	event_scoreboard sb = new();

	logic [7:0] txt_q[$];
	bit         quiet = 1'b0;
	bit         rand_eot = 1'b0;
	bit         hold_req = 1'b0;
	int         cycle_count = 0;

	tagged_text_record_tokenizer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (text_ch),
		.out_ch      (event_ch)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tagged_text_record_tokenizer test failed");
			$finish;
		end
	end

	// event checking on each output transfer
	always @(posedge clk) begin
		if (arst_n && event_ch.valid && event_ch.ready)
			sb.check_result(event_ch.event_kind, event_ch.param_byte,
				event_ch.trim_overflow, event_ch.last_of_run);
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		event_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				event_ch.ready <= 1'b0;
				n = HOLD_CYCLES;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				event_ch.ready <= 1'b0;
				n = $urandom_range(1, 12);
			end else begin
				event_ch.ready <= 1'b1;
				n = $urandom_range(1, 20);
			end
			repeat (n) @(posedge clk);
		end
	end

	// one text byte, optional gap before it
	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			text_ch.valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data_byte <= b;
		text_ch.end_of_text <= eot;
		do @(posedge clk); while (!text_ch.ready);
		sb.note_input(b, eot);
	endtask

	task automatic send_queue(input bit eot_last);
		logic [7:0] b;
		logic       eot;
		while (txt_q.size() > 0) begin
			b = txt_q.pop_front();
			eot = (eot_last && txt_q.size() == 0) ||
				(rand_eot && $urandom_range(0, 99) == 0);
			send_byte(b, eot);
		end
	endtask

	// append one byte to the text queue
	task automatic queue_byte(input logic [7:0] b);
		txt_q.insert(txt_q.size(), b);
	endtask

	task automatic queue_str(input string s);
		for (int k = 0; k < s.len(); k++)
			queue_byte(s[k]);
	endtask

	// sender stops and waits for every expected event
	task automatic drain();
		text_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_cfg(input logic v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.unescape = v;
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// one well-formed record with random content, sometimes followed by noise
	task automatic build_record();
		int n_params;
		int n_pieces;
		int len;
		queue_byte(CH_HASH);
		n_params = $urandom_range(1, 3);
		for (int p = 0; p < n_params; p++) begin
			n_pieces = $urandom_range(0, 4);
			for (int q = 0; q < n_pieces; q++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: queue_byte(8'(8'h61 + $urandom_range(0, 25)));
					3: queue_byte(8'($urandom_range(0, 255)));
					4: begin
						len = $urandom_range(1, 4);
						repeat (len) queue_byte(pick_blank());
					end
					5: begin
						queue_byte(CH_BSL);
						case ($urandom_range(0, 4))
							0: queue_byte(CH_HASH);
							1: queue_byte(CH_SLASH);
							2: queue_byte(CH_SEMI);
							3: queue_byte(CH_BSL);
							default: queue_byte(pick_blank());
						endcase
					end
					6: begin
						queue_byte(CH_SLASH);
						queue_byte(CH_SLASH);
						len = $urandom_range(0, 3);
						repeat (len) queue_byte(8'($urandom_range(0, 255)));
						queue_byte(CH_LF);
					end
					7: begin
						queue_byte(CH_LF);
						len = $urandom_range(0, 2);
						repeat (len) queue_byte(pick_blank());
						queue_byte(CH_HASH);
					end
					8: begin
						queue_byte(CH_SLASH);
						queue_byte(8'(8'h61 + $urandom_range(0, 25)));
					end
					default: begin
						len = $urandom_range(14, 20);
						repeat (len) queue_byte(pick_blank());
					end
				endcase
			end
			queue_byte((p == n_params - 1) ? CH_SEMI : CH_COLON);
		end
		if ($urandom_range(0, 2) == 0) begin
			len = $urandom_range(1, 2);
			repeat (len) queue_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random(input int n_bytes);
		int sent;
		sent = 0;
		rand_eot = 1'b1;
		while (sent < n_bytes) begin
			build_record();
			sent += txt_q.size();
			send_queue(1'b0);
		end
		rand_eot = 1'b0;
	endtask

	// main sequence
	initial begin
		text_ch.valid <= 1'b0;
		text_ch.data_byte <= 8'h00;
		text_ch.end_of_text <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: escapes, comments, held slash, line-start hash, end of text
		write_cfg(1'b1);
		queue_byte(8'h00);
		queue_str("#A\\:");
		queue_byte(8'hFF);
		queue_str(" \t/x//c:\n  #B;\\#");
		send_queue(1'b0);
		queue_str("#C \n");
		send_queue(1'b1);
		queue_str("#\\");
		send_queue(1'b1);
		queue_str("#/");
		send_queue(1'b1);
		queue_str("\\");
		send_queue(1'b1);
		drain();

		// backslash is a plain byte with unescape off
		write_cfg(1'b0);
		queue_str("#a\\:b");
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_str(";\\#z");
		send_queue(1'b1);
		run_random(35);
		drain();

		// long receiver hold-off while the sender keeps going
		write_cfg(1'b1);
		hold_req = 1'b1;
		run_random(60);
		drain();
		run_random(35);
		drain();

		write_cfg(1'b0);
		run_random(20);
		drain();

		// final stretch without idling
		write_cfg(1'b1);
		quiet = 1'b1;
		run_random(30);
		drain();

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("tagged_text_record_tokenizer test passed");
		else
			$display("tagged_text_record_tokenizer test failed");
		$finish;
	end

endmodule
